// ===== sv/dcfd_pkg.sv =====
// Shared constants, command codes and the command decoder for the frame decoder.
`timescale 1ns / 1ps
`default_nettype none
package dcfd_pkg;

  // Frame geometry: positions 0..7 hold bytes, position 8 means overlong
  localparam int unsigned POS_W    = 4;
  localparam logic [3:0]  LAST_POS = 4'd7;

  // Configuration port
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic        REG_START = 1'b0;
  localparam logic        REG_END   = 1'b1;

  // Register reset values
  localparam logic [7:0] START_BYTE_RST = 8'd126;
  localparam logic [7:0] END_BYTE_RST   = 8'd41;

  // Command byte codes carried in frame byte 1
  localparam logic [7:0] CODE_FWD        = 8'h46;
  localparam logic [7:0] CODE_BACK       = 8'h47;
  localparam logic [7:0] CODE_LEFT_ENC   = 8'h42;
  localparam logic [7:0] CODE_RIGHT_ENC  = 8'h43;
  localparam logic [7:0] CODE_STOP       = 8'h72;
  localparam logic [7:0] CODE_LEFT_DEG   = 8'h71;
  localparam logic [7:0] CODE_RIGHT_DEG  = 8'h45;
  localparam logic [7:0] CODE_FWD_DIST   = 8'h70;
  localparam logic [7:0] CODE_BACK_DIST  = 8'h75;

  // Decoded command
  typedef enum logic [3:0] {
    CMD_UNKNOWN   = 4'd0,
    CMD_FWD       = 4'd1,
    CMD_BACK      = 4'd2,
    CMD_LEFT_ENC  = 4'd3,
    CMD_RIGHT_ENC = 4'd4,
    CMD_STOP      = 4'd5,
    CMD_LEFT_DEG  = 4'd6,
    CMD_RIGHT_DEG = 4'd7,
    CMD_FWD_DIST  = 4'd8,
    CMD_BACK_DIST = 4'd9
  } cmd_e;

  // Map a command byte onto its command
  function automatic cmd_e decode_cmd(input logic [7:0] code);
    cmd_e cmd;
    case (code)
      CODE_FWD:       cmd = CMD_FWD;
      CODE_BACK:      cmd = CMD_BACK;
      CODE_LEFT_ENC:  cmd = CMD_LEFT_ENC;
      CODE_RIGHT_ENC: cmd = CMD_RIGHT_ENC;
      CODE_STOP:      cmd = CMD_STOP;
      CODE_LEFT_DEG:  cmd = CMD_LEFT_DEG;
      CODE_RIGHT_DEG: cmd = CMD_RIGHT_DEG;
      CODE_FWD_DIST:  cmd = CMD_FWD_DIST;
      CODE_BACK_DIST: cmd = CMD_BACK_DIST;
      default:        cmd = CMD_UNKNOWN;
    endcase
    return cmd;
  endfunction

endpackage
`default_nettype wire

// ===== sv/delimited_command_frame_decoder.sv =====
// Frame decoder top level: byte register, frame store, result register, APB registers.
// The completing byte enters the byte register, then its result the result register.
// Throughput: one byte per cycle; the byte register advances whenever the result
// register is empty or being drained, so a waiting result does not block bytes
// that complete no frame.
// Reset: position, running distance sum and all valid flags clear; start byte
// resets to 126 and end byte to 41; frame bytes are undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module delimited_command_frame_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Byte channel
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [7:0]                    rx_byte_i,
  // Result channel
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [3:0]                         command_o,
  output logic [15:0]                        ack_number_o,
  output logic [7:0]                         x_value_o,
  output logic [7:0]                         y_value_o,
  output logic [7:0]                         angle_value_o,
  output logic [15:0]                        distance_sum_o,
  // Configuration port
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [dcfd_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [dcfd_pkg::PDATA_W-1:0]  pwdata,
  output logic [dcfd_pkg::PDATA_W-1:0]       prdata,
  output logic                               pready
);

  // Configuration registers
  logic [7:0] start_q;
  logic [7:0] end_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= dcfd_pkg::START_BYTE_RST;
      end_q   <= dcfd_pkg::END_BYTE_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == dcfd_pkg::REG_START) begin
        start_q <= pwdata[7:0];
      end else begin
        end_q <= pwdata[7:0];
      end
    end
  end

  // Read back the selected register
  always_comb begin
    if (paddr[2] == dcfd_pkg::REG_START) begin
      prdata = {{(dcfd_pkg::PDATA_W-8){1'b0}}, start_q};
    end else begin
      prdata = {{(dcfd_pkg::PDATA_W-8){1'b0}}, end_q};
    end
  end

  // Byte register
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_fire;
  logic       out_free;
  logic       out_load;

  // Frame state
  logic [dcfd_pkg::POS_W-1:0] pos_q, pos_d;
  logic [7:0]                 frame_q [1:6];
  logic [15:0]                dist_q, dist_d;

  // Result register
  logic                 out_valid_q;
  dcfd_pkg::cmd_e       cmd_q;
  logic [15:0]          ack_q;
  logic [7:0]           x_q, y_q, angle_q;

  // Classify the held byte
  logic           is_start;
  logic           is_over;
  logic           done;
  dcfd_pkg::cmd_e cmd_dec;

  assign is_start = (s1_byte_q == start_q);
  assign is_over  = (pos_q > dcfd_pkg::LAST_POS);
  assign done     = !is_start && !is_over && (pos_q == dcfd_pkg::LAST_POS) &&
                    (s1_byte_q == end_q);
  assign cmd_dec  = dcfd_pkg::decode_cmd(frame_q[1]);

  // Advance the byte register unless a finished frame must wait for the result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_fire    = s1_valid_q && (!done || out_free);
  assign out_load   = s1_fire && done;
  assign in_ready_o = !s1_valid_q || s1_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= rx_byte_i;
    end
  end

  // Next write position and running distance
  always_comb begin
    pos_d  = pos_q;
    dist_d = dist_q;
    if (s1_fire) begin
      if (is_start) begin
        pos_d = dcfd_pkg::POS_W'(1);
      end else if (is_over || done) begin
        pos_d = '0;
      end else begin
        pos_d = pos_q + dcfd_pkg::POS_W'(1);
      end
      if (done && (cmd_dec == dcfd_pkg::CMD_FWD_DIST)) begin
        dist_d = dist_q + {8'b0, frame_q[4]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      dist_q <= '0;
    end else begin
      pos_q  <= pos_d;
      dist_q <= dist_d;
    end
  end

  // Store bytes 1 to 6; bytes 0 and 7 are never read back
  always_ff @(posedge clk_i) begin
    for (int i = 1; i <= 6; i++) begin
      if (s1_fire && !is_start && !is_over && (pos_q[2:0] == 3'(i))) begin
        frame_q[i] <= s1_byte_q;
      end
    end
  end

  // Result register: load on a completed frame, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      cmd_q   <= cmd_dec;
      ack_q   <= {frame_q[2], frame_q[3]};
      x_q     <= frame_q[4];
      y_q     <= frame_q[5];
      angle_q <= frame_q[6];
    end
  end

  assign out_valid_o    = out_valid_q;
  assign command_o      = cmd_q;
  assign ack_number_o   = ack_q;
  assign x_value_o      = x_q;
  assign y_value_o      = y_q;
  assign angle_value_o  = angle_q;
  assign distance_sum_o = dist_q;

`ifndef SYNTH
  // Position never goes beyond the overlong mark
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= (dcfd_pkg::LAST_POS + dcfd_pkg::POS_W'(1)))
    else $error("write position out of range");

  // A completed frame always returns the position to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (pos_q == '0) && out_valid_q)
    else $error("frame completion did not reset position");

  // A held byte stays put while the result register blocks it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_fire) |=> s1_valid_q && $stable(s1_byte_q))
    else $error("stalled byte lost");

  // The distance sum moves only with a forward-distance result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_q != $past(dist_q)) |-> ($past(out_load) &&
                                   (cmd_q == dcfd_pkg::CMD_FWD_DIST)))
    else $error("distance sum changed without a forward-distance frame");
`endif

endmodule
`default_nettype wire
